// ===== src/swie_pkg.sv =====
package swie_pkg;

    // stage counts of the arithmetic units
    localparam int DIV_STAGES  = 63;  // one setup stage plus one quotient bit per stage
    localparam int SQRT_STAGES = 31;  // one root bit per stage
    localparam int SIDE_DELAY  = DIV_STAGES + SQRT_STAGES;
    localparam int SPEED_DELAY = DIV_STAGES;
    localparam int PIPE_DEPTH  = 2 + SIDE_DELAY + 1;

    localparam logic [30:0] GRAVITY_RESET     = 31'd642908;
    localparam logic [30:0] DEPTH_FLOOR_RESET = 31'd66;
    localparam logic [30:0] Q31_MAX           = 31'h7fff_ffff;

    typedef enum logic [7:0] {
        REG_GRAVITY     = 8'd0,
        REG_DEPTH_FLOOR = 8'd1
    } t_cfg_reg;

    // per item values that ride alongside the long arithmetic units
    typedef struct packed {
        logic signed [31:0] u_left;
        logic signed [31:0] u_right;
        logic signed [31:0] u_center;
        logic [2:0]         depth_ok;
        logic               center_neg;
        logic               center_big;
    } t_side;

endpackage

// ===== src/swie_delay.sv =====
module swie_delay
    import swie_pkg::*;
#(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_pipe [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_data;
            for (int k = 1; k < D; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_data = r_pipe[D-1];

endmodule

// ===== src/swie_qdiv.sv =====
module swie_qdiv
    import swie_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_num,
    input  logic [30:0] i_den,
    output logic [61:0] o_quo,
    output logic        o_ovf
);

    // floor(num * 2^(2F) / den), flagged when the quotient reaches 2^62
    localparam int BITS = DIV_STAGES - 1;

    logic [30:0] r_rem [DIV_STAGES];
    logic [61:0] r_w   [DIV_STAGES];
    logic [30:0] r_den [DIV_STAGES];
    logic        r_ovf [DIV_STAGES];

    logic [92:0] wide;
    logic [30:0] hi;
    logic        ovf;

    assign wide = {62'd0, i_num} << (2 * FRAC_BITS);
    assign hi   = wide[92:62];
    assign ovf  = (hi >= i_den) && (i_num != 31'd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= ovf ? 31'd0 : hi;
            r_w[0]   <= wide[61:0];
            // a zero divisor only survives with a zero numerator, whose quotient is zero
            r_den[0] <= (i_den == 31'd0) ? Q31_MAX : i_den;
            r_ovf[0] <= ovf;
        end
    end

    for (genvar k = 1; k <= BITS; k++) begin : g_bit
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        assign trial = {r_rem[k-1], r_w[k-1][61]};
        assign diff  = trial - {1'b0, r_den[k-1]};
        assign ge    = trial >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[30:0] : trial[30:0];
                r_w[k]   <= {r_w[k-1][60:0], ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_w[BITS];
    assign o_ovf = r_ovf[BITS];

endmodule

// ===== src/swie_isqrt.sv =====
module swie_isqrt
    import swie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_x,
    output logic [30:0] o_root
);

    logic [32:0] r_rem  [SQRT_STAGES];
    logic [30:0] r_root [SQRT_STAGES];
    logic [61:0] r_w    [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
        logic [32:0] p_rem;
        logic [30:0] p_root;
        logic [61:0] p_w;
        logic [32:0] cur;
        logic [32:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_w    = i_x;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_w    = r_w[k-1];
        end

        // bring down the next two bits and try root*4+1
        assign cur   = {p_rem[30:0], p_w[61:60]};
        assign trial = {p_root, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (cur - trial) : cur;
                r_root[k] <= {p_root[29:0], ge};
                r_w[k]    <= {p_w[59:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

// ===== src/shallow_water_interface_eigensystem.sv =====
// from input transfer to result an item passes the 63 stage divider,
// followed by the 31 stage square root, plus input, setup and output stages
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// reset: synchronous active low, clears valid bits, gravity and depth_floor go
// to their defaults
module shallow_water_interface_eigensystem
    import swie_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_h_left,
    input  logic signed [31:0] i_u_left,
    input  logic signed [31:0] i_h_right,
    input  logic signed [31:0] i_u_right,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_left_slow_speed,
    output logic signed [31:0] o_left_fast_speed,
    output logic signed [31:0] o_right_slow_speed,
    output logic signed [31:0] o_right_fast_speed,
    output logic signed [31:0] o_center_slow_speed,
    output logic signed [31:0] o_center_fast_speed,
    output logic               o_well_posed,
    output logic [30:0]        o_left_vector_entry,
    output logic [30:0]        o_right_vector_entry
);

    // configuration registers, always ready
    logic [30:0] r_gravity;
    logic [30:0] r_depth_floor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity     <= GRAVITY_RESET;
            r_depth_floor <= DEPTH_FLOOR_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_GRAVITY) begin
                r_gravity <= i_cfg_data;
            end else if (i_cfg_index == REG_DEPTH_FLOOR) begin
                r_depth_floor <= i_cfg_data;
            end
        end
    end

    // global advance: every stage moves unless a finished result is held
    logic                  ce;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign ce      = ~r_vld[PIPE_DEPTH-1] | i_ready;
    assign o_ready = ce;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // stage 1: capture the transfer and form the floor averaged interface state
    logic signed [31:0] r1_hl, r1_ul, r1_hr, r1_ur, r1_hc, r1_uc;
    logic signed [32:0] h_sum, u_sum;

    assign h_sum = {i_h_left[31], i_h_left} + {i_h_right[31], i_h_right};
    assign u_sum = {i_u_left[31], i_u_left} + {i_u_right[31], i_u_right};

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_hl <= i_h_left;
            r1_ul <= i_u_left;
            r1_hr <= i_h_right;
            r1_ur <= i_u_right;
            r1_hc <= h_sum[32:1];  // arithmetic halve rounds toward minus infinity
            r1_uc <= u_sum[32:1];
        end
    end

    // stage 2: g*h products, divider operands and the side flags
    logic [61:0] r2_prod_l, r2_prod_r, r2_prod_c;
    logic [30:0] r2_ln, r2_ld, r2_rn, r2_rd;
    t_side       r2_side;
    logic        hc_big;

    assign hc_big = ~r1_hc[31] && (r1_hc[30:0] > r_depth_floor);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            // negative depth gives zero celerity
            r2_prod_l <= 62'(r_gravity) * 62'(r1_hl[31] ? 31'd0 : r1_hl[30:0]);
            r2_prod_r <= 62'(r_gravity) * 62'(r1_hr[31] ? 31'd0 : r1_hr[30:0]);
            r2_prod_c <= 62'(r_gravity) * 62'(r1_hc[31] ? 31'd0 : r1_hc[30:0]);
            // h/g and g/h; the right divisor is a dummy when the entry is forced to 0
            r2_ln <= r1_hc[31] ? 31'd0 : r1_hc[30:0];
            r2_ld <= r_gravity;
            r2_rn <= r_gravity;
            r2_rd <= hc_big ? r1_hc[30:0] : 31'd1;
            r2_side.u_left     <= r1_ul;
            r2_side.u_right    <= r1_ur;
            r2_side.u_center   <= r1_uc;
            r2_side.depth_ok   <= {~r1_hc[31], ~r1_hr[31], ~r1_hl[31]};
            r2_side.center_neg <= r1_hc[31];
            r2_side.center_big <= hc_big;
        end
    end

    // celerities: square root, then held until the eigenvector entries catch up
    logic [30:0] c_l, c_r, c_c;
    logic [92:0] c_all, c_dly;

    swie_isqrt u_sqrt_l (.i_clk, .i_en(ce), .i_x(r2_prod_l), .o_root(c_l));
    swie_isqrt u_sqrt_r (.i_clk, .i_en(ce), .i_x(r2_prod_r), .o_root(c_r));
    swie_isqrt u_sqrt_c (.i_clk, .i_en(ce), .i_x(r2_prod_c), .o_root(c_c));

    assign c_all = {c_l, c_r, c_c};

    swie_delay #(.W(93), .D(SPEED_DELAY)) u_dly_c (
        .i_clk, .i_en(ce), .i_data(c_all), .o_data(c_dly)
    );

    // eigenvector entries: quotient, then square root
    logic [61:0] q_l, q_r;
    logic        ovf_l, ovf_r;
    logic [1:0]  ovf_dly;
    logic [30:0] s_l, s_r;

    swie_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div_l (
        .i_clk, .i_en(ce), .i_num(r2_ln), .i_den(r2_ld), .o_quo(q_l), .o_ovf(ovf_l)
    );
    swie_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div_r (
        .i_clk, .i_en(ce), .i_num(r2_rn), .i_den(r2_rd), .o_quo(q_r), .o_ovf(ovf_r)
    );

    swie_isqrt u_sqrt_ql (.i_clk, .i_en(ce), .i_x(q_l), .o_root(s_l));
    swie_isqrt u_sqrt_qr (.i_clk, .i_en(ce), .i_x(q_r), .o_root(s_r));

    swie_delay #(.W(2), .D(SQRT_STAGES)) u_dly_ovf (
        .i_clk, .i_en(ce), .i_data({ovf_l, ovf_r}), .o_data(ovf_dly)
    );

    // velocities and flags ride along the full arithmetic depth
    t_side side_dly;

    swie_delay #(.W($bits(t_side)), .D(SIDE_DELAY)) u_dly_side (
        .i_clk, .i_en(ce), .i_data(r2_side), .o_data(side_dly)
    );

    // output stage: saturated speeds and the final entries
    function automatic logic [31:0] sat_speed(input logic signed [31:0] u,
                                              input logic [30:0] c,
                                              input logic sub);
        logic signed [33:0] u_x;
        logic signed [33:0] c_x;
        logic signed [33:0] v;
        u_x = {{2{u[31]}}, u};
        c_x = {3'b000, c};
        v   = sub ? (u_x - c_x) : (u_x + c_x);
        if (v > 34'sh0_7fff_ffff) begin
            return 32'h7fff_ffff;
        end else if (v < -34'sh0_8000_0000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    logic [30:0] root_l, root_r;

    assign root_l = ovf_dly[1] ? Q31_MAX : s_l;
    assign root_r = ovf_dly[0] ? Q31_MAX : s_r;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            o_left_slow_speed    <= sat_speed(side_dly.u_left,   c_dly[92:62], 1'b1);
            o_left_fast_speed    <= sat_speed(side_dly.u_left,   c_dly[92:62], 1'b0);
            o_right_slow_speed   <= sat_speed(side_dly.u_right,  c_dly[61:31], 1'b1);
            o_right_fast_speed   <= sat_speed(side_dly.u_right,  c_dly[61:31], 1'b0);
            o_center_slow_speed  <= sat_speed(side_dly.u_center, c_dly[30:0],  1'b1);
            o_center_fast_speed  <= sat_speed(side_dly.u_center, c_dly[30:0],  1'b0);
            o_well_posed         <= &side_dly.depth_ok;
            o_left_vector_entry  <= side_dly.center_neg ? 31'd0 : {1'b0, root_l[30:1]};
            o_right_vector_entry <= side_dly.center_big ? root_r : 31'd0;
        end
    end

endmodule

// ===== tb/tb_shallow_water_interface_eigensystem.sv =====
module tb_shallow_water_interface_eigensystem
    import swie_pkg::*;
();

    localparam int FB = 16;
    localparam int LATENCY = 97;
    localparam int WATCHDOG_LIMIT = 20000;

    // one result item of the block
    typedef struct packed {
        logic signed [31:0] left_slow;
        logic signed [31:0] left_fast;
        logic signed [31:0] right_slow;
        logic signed [31:0] right_fast;
        logic signed [31:0] center_slow;
        logic signed [31:0] center_fast;
        logic               well_posed;
        logic [30:0]        left_entry;
        logic [30:0]        right_entry;
    } t_eigen;

    // predicts the eigensystem of each cell pair and checks results in order
    class eigen_scoreboard;
        logic [30:0] gravity;
        logic [30:0] depth_floor;
        t_eigen      pending[$];
        int          mismatches;

        function new();
            gravity     = GRAVITY_RESET;
            depth_floor = DEPTH_FLOOR_RESET;
            mismatches  = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [30:0] val);
            if (idx == REG_GRAVITY) gravity = val;
            else if (idx == REG_DEPTH_FLOOR) depth_floor = val;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // floor(num * 2^(2F) / den), capped at 2^62
        function longint unsigned scaled_quotient(longint unsigned num, longint unsigned den);
            longint unsigned a;
            longint unsigned q;
            longint unsigned r;
            if (den == 0) return (num == 0) ? 64'd0 : (64'd1 << 62);
            a = num << FB;
            q = a / den;
            r = a % den;
            if (q >= (64'd1 << (62 - FB))) return 64'd1 << 62;
            return (q << FB) + ((r << FB) / den);
        endfunction

        function longint unsigned root_sat31(longint unsigned x);
            longint unsigned s;
            s = int_sqrt(x);
            return (s > 64'h7fff_ffff) ? 64'h7fff_ffff : s;
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sh7fff_ffff) return 32'sh7fff_ffff;
            if (v < -64'sh8000_0000) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        // arithmetic shift gives the floor of half
        function longint floor_half(longint s);
            return s >>> 1;
        endfunction

        function logic wave_speeds(longint h, longint u,
                                   output logic signed [31:0] slow,
                                   output logic signed [31:0] fast);
            longint c;
            c = 0;
            if (h >= 0) c = longint'(int_sqrt(longint'(gravity) * h));
            slow = clamp32(u - c);
            fast = clamp32(u + c);
            return h >= 0;
        endfunction

        function void note_input(logic signed [31:0] hl, logic signed [31:0] ul,
                                 logic signed [31:0] hr, logic signed [31:0] ur);
            t_eigen e;
            longint hc;
            longint uc;
            logic ok;
            hc = floor_half(longint'(hl) + longint'(hr));
            uc = floor_half(longint'(ul) + longint'(ur));
            ok = wave_speeds(hl, ul, e.left_slow, e.left_fast);
            ok &= wave_speeds(hr, ur, e.right_slow, e.right_fast);
            ok &= wave_speeds(hc, uc, e.center_slow, e.center_fast);
            e.well_posed = ok;
            e.left_entry = '0;
            e.right_entry = '0;
            if (hc >= 0) e.left_entry = 31'(root_sat31(scaled_quotient(hc, gravity)) >> 1);
            if (hc > longint'(depth_floor))
                e.right_entry = 31'(root_sat31(scaled_quotient(gravity, hc)));
            pending.push_back(e);
        endfunction

        function void check_result(t_eigen got);
            t_eigen want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected %h", want);
                    $display("          actual   %h", got);
                end
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic signed [31:0] i_h_left = 0, i_u_left = 0, i_h_right = 0, i_u_right = 0;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index = 0;
    logic [30:0]        i_cfg_data = 0;
    logic               o_valid;
    logic               i_ready = 0;
    t_eigen             result_bus;

    eigen_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  hold_output = 0;   // long receiver stall requested by the stimulus
    bit  timed_out = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    shallow_water_interface_eigensystem DUT (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready,
        .i_h_left, .i_u_left, .i_h_right, .i_u_right,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_valid, .i_ready,
        .o_left_slow_speed(result_bus.left_slow),
        .o_left_fast_speed(result_bus.left_fast),
        .o_right_slow_speed(result_bus.right_slow),
        .o_right_fast_speed(result_bus.right_fast),
        .o_center_slow_speed(result_bus.center_slow),
        .o_center_fast_speed(result_bus.center_fast),
        .o_well_posed(result_bus.well_posed),
        .o_left_vector_entry(result_bus.left_entry),
        .o_right_vector_entry(result_bus.right_entry)
    );

    // sample transfers at the edge; drive-side updates are nonblocking so no race
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_h_left, i_u_left, i_h_right, i_u_right);
            if (o_valid && i_ready) sb.check_result(result_bus);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall per result, plus a long hold when asked
    initial begin
        int wait_n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_output) begin
                i_ready <= 0;
                @(posedge i_clk);
            end else begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                if ($urandom_range(0, 9) < 3) wait_n = 0;  // stretches of full rate
                if (wait_n > 0) begin
                    i_ready <= 0;
                    repeat (wait_n) @(posedge i_clk);
                end
                i_ready <= 1;
                @(posedge i_clk iff (o_valid && i_ready));
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic cfg_write(t_cfg_reg idx, logic [30:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk iff o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // one cell pair; with gaps set, a random idle gap may come before it, sometimes none
    task automatic send_pair(logic signed [31:0] hl, logic signed [31:0] ul,
                             logic signed [31:0] hr, logic signed [31:0] ur, bit gaps);
        int gap;
        gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1;
        i_h_left  <= hl;
        i_u_left  <= ul;
        i_h_right <= hr;
        i_u_right <= ur;
        @(posedge i_clk iff o_ready);
    endtask

    task automatic drain();
        i_valid <= 0;
        wait (sb.pending.size() == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // mostly physical depths, sometimes any 32 bit pattern
    function automatic logic signed [31:0] rand_depth();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return -$signed({1'b0, 31'($urandom_range(0, 200000))});
            2:       return $urandom_range(0, 200);
            3:       return 32'($urandom_range(0, 32'h7fff_ffff));
            default: return $urandom_range(0, 40 << FB);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_velocity();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return $signed(32'($urandom_range(0, 40 << FB))) - (20 << FB);
    endfunction

    task automatic random_block(int n);
        for (int k = 0; k < n; k++)
            send_pair(rand_depth(), rand_velocity(), rand_depth(), rand_velocity(), 1);
    endtask

    localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, negative depths, odd sums, small depth near the limit
        send_pair(0, 0, 0, 0, 0);
        send_pair(SMAX, SMAX, SMAX, SMAX, 0);
        send_pair(SMIN, SMIN, SMIN, SMIN, 0);
        send_pair(SMAX, SMIN, SMIN, SMAX, 0);
        send_pair(-1, 0, 0, 0, 0);
        send_pair(1 << FB, 1 << FB, -(1 << FB), 0, 0);
        send_pair(-1, -1, 0, 0, 0);
        send_pair(66, 0, 66, 0, 0);
        send_pair(67, 0, 67, 0, 0);
        send_pair(65, 0, 68, 0, 0);
        send_pair(1, 0, 0, 0, 0);
        send_pair(SMAX, 0, 0, 0, 0);
        send_pair(10 << FB, SMAX, 10 << FB, SMIN, 0);
        send_pair(32'h5555_5555, 32'haaaa_aaaa, 32'h2aaa_aaaa, 32'h5555_5555, 0);
        drain();

        // tiny gravity saturates h/g, max gravity saturates speeds
        cfg_write(REG_GRAVITY, 31'd1);
        cfg_write(REG_DEPTH_FLOOR, 31'd0);
        send_pair(SMAX, 0, SMAX, 0, 0);
        send_pair(1, 0, 1, 0, 0);
        send_pair(0, 0, 1, 0, 0);
        drain();
        cfg_write(REG_GRAVITY, Q31_MAX);
        cfg_write(REG_DEPTH_FLOOR, Q31_MAX);
        send_pair(SMAX, SMAX, SMAX, 0, 0);
        send_pair(1, SMIN, 1, 0, 0);
        send_pair(SMAX, 0, SMAX - 1, 0, 0);
        drain();

        // random phases through several register settings
        cfg_write(REG_GRAVITY, GRAVITY_RESET);
        cfg_write(REG_DEPTH_FLOOR, DEPTH_FLOOR_RESET);
        random_block(500);

        // long receiver hold while items keep coming, so the pipe fills
        hold_output = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_output = 0;
            end
            random_block(200);
        join
        drain();   // sender waits for every result

        cfg_write(REG_GRAVITY, 31'($urandom_range(1, 32'h7fff_ffff)));
        cfg_write(REG_DEPTH_FLOOR, 31'($urandom_range(0, 1000)));
        random_block(400);
        drain();

        cfg_write(REG_GRAVITY, 31'($urandom_range(1, 100)));
        cfg_write(REG_DEPTH_FLOOR, 31'($urandom()));
        random_block(300);
        drain();

        cfg_write(REG_GRAVITY, Q31_MAX);
        cfg_write(REG_DEPTH_FLOOR, 31'd0);
        random_block(300);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
